### design/checksummed_frame_receiver_assert.svh
// assertion macros for the checksummed frame receiver
`ifndef CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define CFR_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("checksummed_frame_receiver: assertion failed");
// next-cycle implication, checked outside reset
`define CFR_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("checksummed_frame_receiver: assertion failed");
`else
`define CFR_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define CFR_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

### design/cfr_pkg.sv
package cfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int POS_W  = 5;

  // configuration register indexes
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

  localparam logic [7:0] START_MARKER_RST = 8'd170;
  localparam logic [7:0] END_MARKER_RST   = 8'd85;
  localparam logic [5:0] LENGTH_LIMIT_RST = 6'd32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_SUM_ERR = 2'd2,
    ST_END_ERR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_ID         = 3'd1,
    PH_LENGTH     = 3'd2,
    PH_PAYLOAD    = 3'd3,
    PH_CHECK      = 3'd4,
    PH_END        = 3'd5,
    PH_READ       = 3'd6,
    PH_READ_WAIT  = 3'd7
  } phase_t;

endpackage

### design/checksummed_frame_receiver.sv
// checksummed frame receiver: start, id, length, payload, checksum, end
// result timing: a failed or empty frame gives its registered result in the cycle after the closing byte transfer
// throughput: 1 received byte per cycle while a frame is taken in and the output register is free
// payload readout: per result, a memory read, then an output load once the output register is free
// reset: rst is synchronous, active high; phase, frame state, output valid and config registers return to defaults
`include "checksummed_frame_receiver_assert.svh"

module checksummed_frame_receiver
  import cfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // received bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // frame results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] status, [9:2] frame_tag, [15:10] frame_length,
                                 // [23:16] data_byte, [28:24] data_position, [31:29] zero
  output logic        m_tuser,   // [0] has_data
  output logic        m_tlast    // last
);

  // payload store address width, at least one bit
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W:0] MAX_LIMIT = (LEN_W + 1)'(MAX_PAYLOAD);

  // configuration registers
  logic [7:0]       start_marker;
  logic [7:0]       end_marker;
  logic [LEN_W-1:0] length_limit;

  // frame state
  phase_t           phase, phase_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       held_tag, held_tag_next;
  logic [LEN_W-1:0] held_length, held_length_next;
  logic [LEN_W-1:0] write_position, write_position_next;
  logic [LEN_W-1:0] rd_pos, rd_pos_next;

  // payload store, one write and one registered read port
  logic [7:0]       payload_mem [MAX_PAYLOAD];
  logic [7:0]       rd_data;
  logic             mem_we;
  logic             mem_re;

  // output register
  logic             out_valid;
  status_t          o_status;
  logic [7:0]       o_tag;
  logic [LEN_W-1:0] o_len;
  logic             o_has;
  logic [7:0]       o_data;
  logic [POS_W-1:0] o_pos;
  logic             o_last;

  // result load from this cycle's work
  logic             ld;
  status_t          ld_status;
  logic [LEN_W-1:0] ld_len;
  logic             ld_has;
  logic             ld_last;

  logic             out_free;
  logic             in_xfer;
  logic             rx_phase;
  logic [LEN_W:0]   limit;
  logic             len_bad;
  logic [LEN_W-1:0] wp_inc;
  logic             rd_last;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid || m_tready;
  // bytes are taken only outside the payload readout
  assign rx_phase = (phase != PH_READ) && (phase != PH_READ_WAIT);
  assign s_tready = rx_phase && out_free;
  assign in_xfer  = s_tvalid && s_tready;

  // effective length limit, saturated to the store depth
  assign limit   = ({1'b0, length_limit} > MAX_LIMIT) ? MAX_LIMIT : {1'b0, length_limit};
  assign len_bad = s_tdata > {1'b0, limit};
  assign wp_inc  = write_position + LEN_W'(1);
  assign rd_last = (rd_pos + LEN_W'(1)) == held_length;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
      length_limit <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_data;
        REG_END_MARKER:   end_marker   <= cfg_data;
        REG_LENGTH_LIMIT: length_limit <= cfg_data[LEN_W-1:0];
        default: ;  // index beyond the list, write dropped
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_WAIT_START: if (in_xfer && s_tdata == start_marker) phase_next = PH_ID;
      PH_ID:         if (in_xfer) phase_next = PH_LENGTH;
      PH_LENGTH: begin
        if (in_xfer) begin
          if (len_bad)              phase_next = PH_WAIT_START;
          else if (s_tdata == 8'd0) phase_next = PH_CHECK;
          else                      phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD:    if (in_xfer && wp_inc >= held_length) phase_next = PH_CHECK;
      PH_CHECK: begin
        if (in_xfer) phase_next = (s_tdata != running_sum) ? PH_WAIT_START : PH_END;
      end
      PH_END: begin
        if (in_xfer) begin
          if (s_tdata != end_marker || held_length == '0) phase_next = PH_WAIT_START;
          else                                              phase_next = PH_READ;
        end
      end
      PH_READ:       phase_next = PH_READ_WAIT;
      PH_READ_WAIT:  if (out_free) phase_next = rd_last ? PH_WAIT_START : PH_READ;
      default:       phase_next = PH_WAIT_START;
    endcase
  end

  // datapath and result generation
  always_comb begin
    running_sum_next    = running_sum;
    held_tag_next       = held_tag;
    held_length_next    = held_length;
    write_position_next = write_position;
    rd_pos_next         = rd_pos;
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    ld                  = 1'b0;
    ld_status           = ST_OK;
    ld_len              = held_length;
    ld_has              = 1'b0;
    ld_last             = 1'b1;
    unique case (phase)
      PH_WAIT_START: begin
        if (in_xfer && s_tdata == start_marker) begin
          running_sum_next    = '0;
          held_tag_next       = '0;
          held_length_next    = '0;
          write_position_next = '0;
        end
      end
      PH_ID: begin
        if (in_xfer) begin
          held_tag_next    = s_tdata;
          running_sum_next = s_tdata;
        end
      end
      PH_LENGTH: begin
        if (in_xfer) begin
          if (len_bad) begin
            ld        = 1'b1;
            ld_status = ST_LEN_ERR;
            ld_len    = '0;
          end else begin
            held_length_next = s_tdata[LEN_W-1:0];
            running_sum_next = running_sum + s_tdata;
          end
        end
      end
      PH_PAYLOAD: begin
        if (in_xfer) begin
          mem_we              = 1'b1;
          write_position_next = wp_inc;
          running_sum_next    = running_sum + s_tdata;
        end
      end
      PH_CHECK: begin
        if (in_xfer && s_tdata != running_sum) begin
          ld        = 1'b1;
          ld_status = ST_SUM_ERR;
        end
      end
      PH_END: begin
        if (in_xfer) begin
          rd_pos_next = '0;
          if (s_tdata != end_marker) begin
            ld        = 1'b1;
            ld_status = ST_END_ERR;
          end else if (held_length == '0) begin
            ld = 1'b1;
          end
        end
      end
      PH_READ: mem_re = 1'b1;
      PH_READ_WAIT: begin
        if (out_free) begin
          ld          = 1'b1;
          ld_has      = 1'b1;
          ld_last     = rd_last;
          rd_pos_next = rd_pos + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT_START;
      running_sum    <= '0;
      held_tag       <= '0;
      held_length    <= '0;
      write_position <= '0;
      rd_pos         <= '0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      held_tag       <= held_tag_next;
      held_length    <= held_length_next;
      write_position <= write_position_next;
      rd_pos         <= rd_pos_next;
      if (ld)            out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (ld) begin
      o_status <= ld_status;
      o_tag    <= held_tag;
      o_len    <= ld_len;
      o_has    <= ld_has;
      o_data   <= ld_has ? rd_data : 8'd0;
      o_pos    <= ld_has ? rd_pos[POS_W-1:0] : '0;
      o_last   <= ld_last;
    end
  end

  // payload store: written while the payload streams in, read back after the end byte
  always_ff @(posedge clk) begin
    if (mem_we) payload_mem[write_position[AW-1:0]] <= s_tdata;
    if (mem_re) rd_data <= payload_mem[rd_pos[AW-1:0]];
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, o_pos, o_data, o_len, o_tag, o_status};
  assign m_tuser  = o_has;
  assign m_tlast  = o_last;

  // no input transfer during readout
  `CFR_ASSERT_IMP(a_no_rx_in_readout, clk, rst, !rx_phase, !s_tready)
  // a store read is always followed by its data cycle
  `CFR_ASSERT_NXT(a_read_then_wait, clk, rst, phase == PH_READ, phase == PH_READ_WAIT)
  // payload writes stay inside the announced length
  `CFR_ASSERT_IMP(a_wp_in_frame, clk, rst, phase == PH_PAYLOAD, write_position < held_length)
  // readout position stays inside the frame
  `CFR_ASSERT_IMP(a_rd_in_frame, clk, rst, phase == PH_READ_WAIT, rd_pos < held_length)

endmodule
